// ===== rtl/fls_pkg.sv =====
// ----------------------------------------------------------------------------
// fls_pkg
// Shared types and constants for the five-lamp chase sequencer: beat
// payloads, sequencer state, mode codes and lamp constants.
// ----------------------------------------------------------------------------
package fls_pkg;

  // mode codes
  localparam logic [3:0] MODE_OFF      = 4'd0;
  localparam logic [3:0] MODE_ON       = 4'd1;
  localparam logic [3:0] MODE_FLASH    = 4'd2;
  localparam logic [3:0] MODE_HS_RUN   = 4'd3;
  localparam logic [3:0] MODE_HS_FILL  = 4'd4;
  localparam logic [3:0] MODE_HS_CLOSE = 4'd5;
  localparam logic [3:0] MODE_SH_RUN   = 4'd6;
  localparam logic [3:0] MODE_SH_FILL  = 4'd7;
  localparam logic [3:0] MODE_SH_CLOSE = 4'd8;
  localparam logic [3:0] MODE_SWOFF    = 4'd9;

  // command codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // lamp constants
  localparam logic [4:0] ALL_LAMPS   = 5'h1F;
  localparam logic [2:0] LAST_LAMP   = 3'd4;
  localparam logic [4:0] OUTER_LAMPS = 5'b10001;
  localparam logic [4:0] INNER_LAMPS = 5'b01010;
  localparam logic [4:0] MID_LAMP    = 5'b00100;

  // switch-off hold
  localparam logic [7:0] HOLD_RESET = 8'd101;
  localparam logic [7:0] HOLD_MAX   = 8'd253;

  // input beat
  typedef struct packed {
    logic       cmd;
    logic [3:0] new_mode;
    logic       is_day;
  } item_t;

  // result beat
  typedef struct packed {
    logic [4:0] lamps;
    logic [3:0] mode;
  } result_t;

  // sequencer state
  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] step_index;
    logic       fill_done;
    logic [4:0] lamps;
  } seq_state_t;

endpackage

// ===== rtl/fls_step.sv =====
// ----------------------------------------------------------------------------
// fls_step
// Next-state logic of the sequencer: applies one tick or one mode request
// to the current state.
// ----------------------------------------------------------------------------
module fls_step import fls_pkg::*; (
  input  item_t      item,
  input  logic [7:0] hold_ticks,
  input  seq_state_t cur,
  output seq_state_t nxt
);

  logic [2:0] idx;
  logic [2:0] idx_up;
  logic [2:0] idx_down;
  logic [7:0] hold;
  logic [3:0] req;
  logic [4:0] swoff_lamps;

  // clamped lamp index and its neighbors
  assign idx      = (cur.step_index > 8'(LAST_LAMP)) ? LAST_LAMP : cur.step_index[2:0];
  assign idx_up   = (idx >= LAST_LAMP) ? 3'd0 : idx + 3'd1;
  assign idx_down = (idx == 3'd0) ? LAST_LAMP : idx - 3'd1;

  // hold limited so the three off steps fit in the counter
  assign hold = (hold_ticks > HOLD_MAX) ? HOLD_MAX : hold_ticks;

  // opening requests become closing during switch-off
  always_comb begin
    req = item.new_mode;
    if (cur.mode == MODE_SWOFF) begin
      if (item.new_mode == MODE_SH_RUN) req = MODE_SH_CLOSE;
      if (item.new_mode == MODE_HS_RUN) req = MODE_HS_CLOSE;
    end
  end

  // switch-off lamp pattern, outside toward the middle
  always_comb begin
    swoff_lamps = cur.lamps;
    if (cur.step_index == 8'd0) swoff_lamps = ALL_LAMPS;
    if (cur.step_index == hold) swoff_lamps = swoff_lamps & ~OUTER_LAMPS;
    if (cur.step_index == hold + 8'd1) swoff_lamps = swoff_lamps & ~INNER_LAMPS;
    if (cur.step_index == hold + 8'd2) swoff_lamps = swoff_lamps & ~MID_LAMP;
  end

  // state update
  always_comb begin
    nxt = cur;
    if (item.cmd == CMD_REQUEST) begin
      if (item.is_day) begin
        nxt.mode = MODE_OFF;
      end else if (item.new_mode <= MODE_SWOFF) begin
        if (req != MODE_SH_FILL) nxt.step_index = 8'd0;
        nxt.mode      = req;
        nxt.fill_done = 1'b0;
      end
    end else begin
      case (cur.mode)
        MODE_OFF: begin
          nxt.lamps = 5'd0;
        end
        MODE_ON: begin
          nxt.lamps = ALL_LAMPS;
        end
        MODE_FLASH: begin
          if (cur.step_index != 8'd0) begin
            nxt.step_index = 8'd0;
            nxt.lamps      = ALL_LAMPS;
          end else begin
            nxt.step_index = 8'd1;
            nxt.lamps      = 5'd0;
          end
        end
        MODE_HS_RUN: begin
          nxt.lamps      = (cur.lamps & ~(5'd1 << idx)) | (5'd1 << idx_up);
          nxt.step_index = 8'(idx_up);
        end
        MODE_HS_FILL: begin
          nxt.lamps = cur.lamps | (5'd1 << idx);
          if (idx >= LAST_LAMP) begin
            nxt.step_index = 8'd0;
            if (cur.fill_done) nxt.mode = MODE_ON;
            nxt.fill_done = 1'b1;
          end else begin
            nxt.step_index = 8'(idx_up);
          end
        end
        MODE_HS_CLOSE: begin
          nxt.lamps      = (cur.lamps | (5'd1 << idx)) & ~(5'd1 << idx_up);
          nxt.step_index = 8'(idx_up);
        end
        MODE_SH_RUN: begin
          nxt.lamps      = (cur.lamps & ~(5'd1 << idx)) | (5'd1 << idx_down);
          nxt.step_index = 8'(idx_down);
        end
        MODE_SH_FILL: begin
          nxt.lamps = cur.lamps | (5'd1 << idx);
          if (idx == 3'd0) begin
            nxt.step_index = 8'(LAST_LAMP);
            if (cur.fill_done) nxt.mode = MODE_ON;
            nxt.fill_done = 1'b1;
          end else begin
            nxt.step_index = 8'(idx_down);
          end
        end
        MODE_SH_CLOSE: begin
          nxt.lamps      = (cur.lamps | (5'd1 << idx)) & ~(5'd1 << idx_down);
          nxt.step_index = 8'(idx_down);
        end
        MODE_SWOFF: begin
          nxt.lamps      = swoff_lamps;
          nxt.step_index = cur.step_index + 8'd1;
          if (cur.step_index == hold + 8'd2) nxt.mode = MODE_OFF;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

// ===== rtl/five_lamp_chase_sequencer.sv =====
// ----------------------------------------------------------------------------
// five_lamp_chase_sequencer
// Five-lamp pattern sequencer with ten modes, driven by tick and mode
// request beats, one result beat per input beat.
// ----------------------------------------------------------------------------
// Takes one input beat per clock while item_stall is low and returns one result
// beat per input beat with the lamp pattern and mode after that beat. Each beat
// passes an input register and then the result register, with the state
// update between them. While result_stall is held the result register
// keeps its beat, the input register still fills, and only then does
// item_stall rise. hold_ticks is written through the cfg port (always ready)
// and should only be changed while no beat is in flight.
module five_lamp_chase_sequencer import fls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic       s1_valid;
  item_t      s1_item;
  logic       s1_adv;
  logic       item_fire;
  logic [7:0] hold_ticks;
  seq_state_t state;
  seq_state_t state_next;

  // flow control
  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign item_fire  = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_ticks <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_item <= item;
    end
  end

  // next-state logic
  fls_step u_step (
    .item       (s1_item),
    .hold_ticks (hold_ticks),
    .cur        (state),
    .nxt        (state_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.lamps <= state_next.lamps;
      result.mode  <= state_next.mode;
    end
  end

  // mode stays a legal code
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.mode <= MODE_SWOFF))
    else $error("result mode out of range");

  // a daylight request forces off
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_item.cmd == CMD_REQUEST && s1_item.is_day) |=> (state.mode == MODE_OFF))
    else $error("day request did not force off");

  // a mode request leaves the lamps alone
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_item.cmd == CMD_REQUEST) |=> (state.lamps == $past(state.lamps)))
    else $error("mode request changed lamps");

  // an advancing beat always lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("beat lost between input and result register");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the five-lamp chase sequencer. A clocked driver
// feeds item beats from a pending queue, a clocked monitor compares every
// result beat with the lamp pattern and mode predicted for the item that
// caused it. Both sides idle and stall at random; hold_ticks is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import fls_pkg::*;

  localparam int LONG_HOLD   = 40;
  localparam int STUCK_LIMIT = 1000;
  localparam int PRINT_CAP   = 50;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  // predicted sequencer state and the hold setting it runs with
  logic [3:0] exp_mode      = MODE_OFF;
  logic [7:0] exp_step      = 8'd0;
  logic       exp_fill_done = 1'b0;
  logic [4:0] exp_lamps     = 5'd0;
  logic [7:0] hold_cfg      = HOLD_RESET;

  item_t   pending_items[$];
  result_t expected_beats[$];

  int  send_gap = 0;
  int  stall_gap = 0;
  int  hold_left = 0;
  int  hold_off_requests = 0;
  int  hold_off_served = 0;
  int  stuck_cycles = 0;
  int  mismatches = 0;
  int  beats_queued = 0;
  int  beats_taken = 0;
  int  results_checked = 0;
  int  holds_written = 0;
  bit  idle_off = 1'b0;

  five_lamp_chase_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // next lamp pattern and mode for one item beat
  function automatic result_t advance_lamps(input item_t beat);
    logic [2:0] idx;
    logic [7:0] hold;
    logic [3:0] req;
    result_t    r;
    idx  = (exp_step > {5'd0, LAST_LAMP}) ? LAST_LAMP : exp_step[2:0];
    hold = (hold_cfg > HOLD_MAX) ? HOLD_MAX : hold_cfg;
    if (beat.cmd == CMD_REQUEST) begin
      // daylight forces off and keeps everything else
      if (beat.is_day) begin
        exp_mode = MODE_OFF;
      end else if (beat.new_mode <= MODE_SWOFF) begin
        req = beat.new_mode;
        // opening chase asked during switch-off turns into closing
        if (exp_mode == MODE_SWOFF) begin
          if (req == MODE_SH_RUN) req = MODE_SH_CLOSE;
          if (req == MODE_HS_RUN) req = MODE_HS_CLOSE;
        end
        if (req != MODE_SH_FILL) exp_step = 8'd0;
        exp_mode      = req;
        exp_fill_done = 1'b0;
      end
    end else begin
      case (exp_mode)
        MODE_OFF: exp_lamps = 5'd0;
        MODE_ON:  exp_lamps = ALL_LAMPS;
        MODE_FLASH: begin
          if (exp_step != 8'd0) begin
            exp_step  = 8'd0;
            exp_lamps = ALL_LAMPS;
          end else begin
            exp_step  = 8'd1;
            exp_lamps = 5'd0;
          end
        end
        MODE_HS_RUN: begin
          exp_lamps[idx] = 1'b0;
          idx = (idx >= LAST_LAMP) ? 3'd0 : idx + 3'd1;
          exp_lamps[idx] = 1'b1;
          exp_step = {5'd0, idx};
        end
        MODE_HS_FILL: begin
          exp_lamps[idx] = 1'b1;
          if (idx >= LAST_LAMP) begin
            exp_step = 8'd0;
            if (exp_fill_done) exp_mode = MODE_ON;
            exp_fill_done = 1'b1;
          end else begin
            exp_step = {5'd0, idx + 3'd1};
          end
        end
        MODE_HS_CLOSE: begin
          exp_lamps[idx] = 1'b1;
          idx = (idx >= LAST_LAMP) ? 3'd0 : idx + 3'd1;
          exp_lamps[idx] = 1'b0;
          exp_step = {5'd0, idx};
        end
        MODE_SH_RUN: begin
          exp_lamps[idx] = 1'b0;
          idx = (idx == 3'd0) ? LAST_LAMP : idx - 3'd1;
          exp_lamps[idx] = 1'b1;
          exp_step = {5'd0, idx};
        end
        MODE_SH_FILL: begin
          exp_lamps[idx] = 1'b1;
          if (idx == 3'd0) begin
            exp_step = {5'd0, LAST_LAMP};
            if (exp_fill_done) exp_mode = MODE_ON;
            exp_fill_done = 1'b1;
          end else begin
            exp_step = {5'd0, idx - 3'd1};
          end
        end
        MODE_SH_CLOSE: begin
          exp_lamps[idx] = 1'b1;
          idx = (idx == 3'd0) ? LAST_LAMP : idx - 3'd1;
          exp_lamps[idx] = 1'b0;
          exp_step = {5'd0, idx};
        end
        MODE_SWOFF: begin
          // all on, hold, then dark from the outside in
          if (exp_step == 8'd0) exp_lamps = ALL_LAMPS;
          if (exp_step == hold) exp_lamps &= ~OUTER_LAMPS;
          if (exp_step == hold + 8'd1) exp_lamps &= ~INNER_LAMPS;
          if (exp_step == hold + 8'd2) begin
            exp_lamps &= ~MID_LAMP;
            exp_mode = MODE_OFF;
          end
          exp_step = exp_step + 8'd1;
        end
        default: ;
      endcase
    end
    r.lamps = exp_lamps;
    r.mode  = exp_mode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s mismatch, got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // item driver: hold while stalled, else idle burst or next pending beat
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_beats.push_back(advance_lamps(item));
        beats_taken++;
      end
      if (!(item_valid && item_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, receiver stall and quiet-cycle count
  always @(posedge clk) begin : collect
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_gap = 0;
      hold_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected result beat", {3'd0, result.lamps}, 8'd0);
        end else begin
          want = expected_beats.pop_front();
          if (result.lamps !== want.lamps)
            report_mismatch("lamps", {3'd0, result.lamps}, {3'd0, want.lamps});
          if (result.mode !== want.mode)
            report_mismatch("mode", {4'd0, result.mode}, {4'd0, want.mode});
        end
        results_checked++;
      end
      // stall: long hold-off on request, else random bursts
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_off_served < hold_off_requests) begin
        hold_off_served++;
        hold_left = LONG_HOLD - 1;
        result_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        result_stall <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 4);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
  end

  // watchdog on cycles with no beat moving
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic item_t make_item(input logic c, input logic [3:0] m, input logic d);
    item_t it;
    it.cmd      = c;
    it.new_mode = m;
    it.is_day   = d;
    return it;
  endfunction

  task automatic queue_item(input logic c, input logic [3:0] m, input logic d);
    pending_items.push_back(make_item(c, m, d));
    beats_queued++;
  endtask

  // ticks carry random don't-care bits in the other fields
  task automatic queue_ticks(input int n);
    repeat (n) queue_item(CMD_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_request(input logic [3:0] m);
    queue_item(CMD_REQUEST, m, 1'b0);
  endtask

  // mostly mode request followed by a run of ticks, some day, bad and noise beats
  task automatic queue_random(input int count);
    int done;
    int pick;
    int n;
    item_t it;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      n    = $urandom_range(1, 30);
      if (pick < 70) begin
        queue_request(4'($urandom_range(0, 9)));
        queue_ticks(n);
        done += n + 1;
      end else if (pick < 80) begin
        queue_item(CMD_REQUEST, 4'($urandom_range(0, 15)), 1'b1);
        queue_ticks(n % 5 + 1);
        done += n % 5 + 2;
      end else if (pick < 88) begin
        queue_request(4'($urandom_range(10, 15)));
        queue_ticks(n % 5 + 1);
        done += n % 5 + 1;
      end else begin
        it = make_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)));
        pending_items.push_back(it);
        beats_queued++;
        if (!(it.cmd == CMD_REQUEST && !it.is_day && it.new_mode > MODE_SWOFF)) done++;
      end
    end
  endtask

  // every queued beat taken and every result back
  task automatic wait_idle();
    @(posedge clk);
    while (beats_taken != beats_queued || expected_beats.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_hold(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hold_cfg = value;
    cfg_valid <= 1'b0;
    holds_written++;
  endtask

  // stimulus phases
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // all modes but SWOFF, SH_FILL at reset hold, bad and day requests, two fill passes
    queue_ticks(1);
    queue_request(MODE_ON);    queue_ticks(1);
    queue_request(MODE_FLASH); queue_ticks(2);
    queue_request(MODE_HS_RUN); queue_ticks(2);
    queue_request(MODE_SH_RUN); queue_ticks(2);
    queue_request(MODE_HS_CLOSE); queue_ticks(1);
    queue_request(MODE_SH_CLOSE); queue_ticks(1);
    queue_request(4'd12);
    queue_item(CMD_REQUEST, MODE_HS_FILL, 1'b1);
    queue_request(MODE_HS_FILL); queue_ticks(10);
    wait_idle();

    // hold zero, opening turned into closing, full switch-off
    write_hold(8'd0);
    queue_request(MODE_SWOFF); queue_ticks(1);
    queue_request(MODE_SH_RUN); queue_ticks(1);
    queue_request(MODE_SWOFF); queue_ticks(1);
    queue_request(MODE_HS_RUN); queue_ticks(1);
    queue_request(MODE_SWOFF); queue_ticks(3);
    queue_request(MODE_HS_RUN); queue_ticks(1);
    wait_idle();

    // hold shortened mid switch-off so the count wraps through 255
    write_hold(8'd250);
    queue_request(MODE_SWOFF); queue_ticks(100);
    wait_idle();
    write_hold(8'd10);
    queue_ticks(170);
    // large index kept across a day request into the street-to-house fill
    queue_request(MODE_SWOFF); queue_ticks(6);
    queue_item(CMD_REQUEST, MODE_ON, 1'b1); queue_ticks(1);
    queue_request(MODE_SH_FILL); queue_ticks(12);
    wait_idle();

    // hold above the clamp
    write_hold(8'd255);
    queue_request(MODE_SWOFF); queue_ticks(258);
    wait_idle();

    // random with a long receiver hold-off while the sender keeps offering
    write_hold(8'($urandom_range(1, 20)));
    queue_random(200);
    hold_off_requests <= hold_off_requests + 1;
    wait_idle();

    write_hold(8'd1);
    queue_random(200);
    // sender pause until every result is back
    wait_idle();
    write_hold(8'($urandom_range(2, 30)));
    queue_random(150);
    wait_idle();

    // closing stretch with no idling on either side
    write_hold(8'($urandom_range(1, 20)));
    idle_off = 1'b1;
    queue_random(150);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("covered %0d item beats, %0d result beats, %0d hold_ticks writes",
             beats_taken, results_checked, holds_written);
    $display("including hold 0, 1, 250 and 255, switch-off wrap and a long output stall");
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fls_pkg.sv
rtl/fls_step.sv
rtl/five_lamp_chase_sequencer.sv
tb/testbench.sv
